// File: hdl/pbu_pkg.sv
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants of the planar bitmap body unpacker: register
// indexes, default register values, decoder phases and the result record.
// ----------------------------------------------------------------------------
package pbu_pkg;

    // Parameter defaults
    localparam int MAX_PLANES_DEF = 25;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED   = 3'd4;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd320;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd200;
    localparam logic [4:0]  RST_PLANE_COUNT  = 5'd5;
    localparam logic        RST_HAS_MASK     = 1'b0;
    localparam logic        RST_COMPRESSED   = 1'b1;

    // PackBits header that does nothing
    localparam logic [7:0] NOOP_HEADER = 8'd128;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  run_length;
        logic [4:0]  plane;
        logic        is_mask;
        logic [11:0] row;
        logic [8:0]  column;
        logic        last;
        logic        error;
    } t_result;

endpackage

// File: hdl/pbu_out_buf.sv
// ----------------------------------------------------------------------------
// pbu_out_buf
// Two-entry result queue. Lets the decoder take a new byte while a finished
// run still waits on the output side.
// ----------------------------------------------------------------------------
module pbu_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pbu_pkg::t_result i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_ready,
    output pbu_pkg::t_result o_data
);

    pbu_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    logic pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/planar_bitmap_body_unpacker_top.sv
// ----------------------------------------------------------------------------
// planar_bitmap_body_unpacker_top
// PackBits / raw body decoder for interleaved planar bitmaps.
// ----------------------------------------------------------------------------
// Takes one body byte per clock while the output queue is not full and gives
// at most one run per byte. A byte is registered at the input, decoded from
// that register against the row, plane and column counters, and the run is
// written into a two-entry output queue that drives o_valid. The column,
// plane and row updates are combinational adds and compares, which set the
// one-byte-per-cycle rate; the input side only stalls when the output queue
// is full. A write to any configuration register restarts decoding at
// row 0, plane 0, column 0 and clears the error and end-of-image flags. After
// an overrun error or after the last run of the image, further bytes are
// taken and dropped.
// ----------------------------------------------------------------------------
module planar_bitmap_body_unpacker_top #(
    parameter int MAX_PLANES = pbu_pkg::MAX_PLANES_DEF,
    parameter int MAX_WIDTH  = pbu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pbu_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [pbu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // body bytes
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_body_byte,
    // runs
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_value,
    output logic [7:0]                     o_run_length,
    output logic [4:0]                     o_plane,
    output logic                           o_is_mask,
    output logic [11:0]                    o_row,
    output logic [8:0]                     o_column,
    output logic                           o_last,
    output logic                           o_error
);

    localparam int RB_MAX = ((MAX_WIDTH + 15) / 16) * 2;
    localparam int COL_W  = $clog2(RB_MAX + 1);
    localparam int SUM_W  = ((COL_W > 8) ? COL_W : 8) + 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PL_W   = $clog2(MAX_PLANES);

    // configuration registers
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic [4:0]  r_plane_count;
    logic        r_has_mask;
    logic        r_compressed;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // decoder state
    pbu_pkg::t_phase r_phase,   n_phase;
    logic [7:0]      r_pending, n_pending;
    logic [COL_W-1:0] r_col,    n_col;
    logic [PL_W-1:0] r_plane,   n_plane;
    logic [ROW_W-1:0] r_row,    n_row;
    logic            r_error,   n_error;
    logic            r_done,    n_done;

    // derived geometry
    logic [14:0]      eff_w;
    logic [14:0]      rb_full;
    logic [COL_W-1:0] row_bytes;
    logic [SUM_W-1:0] bytes_left;
    logic [13:0]      eff_h;
    logic [5:0]       eff_planes;
    logic [5:0]       total_planes;

    // decode decisions
    logic             advance;
    logic             buf_full;
    logic             emit;
    logic             emit_err;
    logic             emit_last;
    logic [7:0]       emit_len;
    logic [7:0]       hdr_n;
    logic [SUM_W-1:0] col_sum;
    logic [5:0]       plane_inc;
    logic [13:0]      row_inc;
    logic             restart;

    pbu_pkg::t_result result;
    pbu_pkg::t_result out_data;

    assign advance = r_in_valid && !buf_full;
    assign o_ready = !r_in_valid || !buf_full;
    assign restart = i_cfg_we && (i_cfg_index == pbu_pkg::CFG_IMAGE_WIDTH  ||
                                  i_cfg_index == pbu_pkg::CFG_IMAGE_HEIGHT ||
                                  i_cfg_index == pbu_pkg::CFG_PLANE_COUNT  ||
                                  i_cfg_index == pbu_pkg::CFG_HAS_MASK     ||
                                  i_cfg_index == pbu_pkg::CFG_COMPRESSED);

    // ---------------------------------------------------------------- geometry
    always_comb begin
        eff_w = {2'b00, r_image_width};
        if (eff_w == 15'd0) begin
            eff_w = 15'd1;
        end else if (eff_w > 15'(MAX_WIDTH)) begin
            eff_w = 15'(MAX_WIDTH);
        end
        rb_full    = ((eff_w + 15'd15) >> 4) << 1;
        row_bytes  = COL_W'(rb_full);
        bytes_left = SUM_W'(row_bytes) - SUM_W'(r_col);

        eff_h = {1'b0, r_image_height};
        if (eff_h == 14'd0) begin
            eff_h = 14'd1;
        end else if (eff_h > 14'(MAX_HEIGHT)) begin
            eff_h = 14'(MAX_HEIGHT);
        end

        eff_planes = {1'b0, r_plane_count};
        if (eff_planes == 6'd0) begin
            eff_planes = 6'd1;
        end else if (eff_planes > 6'(MAX_PLANES - 1)) begin
            eff_planes = 6'(MAX_PLANES - 1);
        end
        total_planes = eff_planes + {5'd0, r_has_mask};
    end

    // -------------------------------------------------------------- next state
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_col     = r_col;
        n_plane   = r_plane;
        n_row     = r_row;
        n_error   = r_error;
        n_done    = r_done;
        emit      = 1'b0;
        emit_err  = 1'b0;
        emit_last = 1'b0;
        emit_len  = 8'd1;
        hdr_n     = (r_in_byte < pbu_pkg::NOOP_HEADER) ? (r_in_byte + 8'd1)
                                                       : 8'(9'd257 - {1'b0, r_in_byte});
        col_sum   = '0;
        plane_inc = '0;
        row_inc   = '0;

        if (advance && !r_error && !r_done) begin
            if (!r_compressed) begin
                emit = 1'b1;
            end else begin
                unique case (r_phase)
                    pbu_pkg::PH_LITERAL: begin
                        emit = 1'b1;
                        if (r_pending <= 8'd1) begin
                            n_pending = 8'd0;
                            n_phase   = pbu_pkg::PH_HEADER;
                        end else begin
                            n_pending = r_pending - 8'd1;
                        end
                    end
                    pbu_pkg::PH_REPEAT: begin
                        emit      = 1'b1;
                        emit_len  = (r_pending == 8'd0) ? 8'd1 : r_pending;
                        n_pending = 8'd0;
                        n_phase   = pbu_pkg::PH_HEADER;
                    end
                    default: begin
                        if (r_in_byte != pbu_pkg::NOOP_HEADER) begin
                            if (SUM_W'(hdr_n) > bytes_left) begin
                                emit_err = 1'b1;
                                n_error  = 1'b1;
                            end else begin
                                n_pending = hdr_n;
                                n_phase   = (r_in_byte < pbu_pkg::NOOP_HEADER) ?
                                            pbu_pkg::PH_LITERAL : pbu_pkg::PH_REPEAT;
                            end
                        end
                    end
                endcase
            end

            // advance column, plane and row past the run
            if (emit) begin
                col_sum = SUM_W'(r_col) + SUM_W'(emit_len);
                if (col_sum >= SUM_W'(row_bytes)) begin
                    n_col     = '0;
                    plane_inc = 6'(r_plane) + 6'd1;
                    if (plane_inc >= total_planes) begin
                        n_plane = '0;
                        row_inc = 14'(r_row) + 14'd1;
                        if (row_inc >= eff_h) begin
                            n_row     = '0;
                            n_done    = 1'b1;
                            emit_last = 1'b1;
                        end else begin
                            n_row = ROW_W'(row_inc);
                        end
                    end else begin
                        n_plane = PL_W'(plane_inc);
                    end
                end else begin
                    n_col = COL_W'(col_sum);
                end
            end
        end
    end

    // ------------------------------------------------------------------ result
    always_comb begin
        result = '0;
        if (emit_err) begin
            result.error = 1'b1;
        end else begin
            result.value      = r_in_byte;
            result.run_length = emit_len;
            result.plane      = 5'(r_plane);
            result.is_mask    = r_has_mask && (6'(r_plane) == eff_planes);
            result.row        = 12'(r_row);
            result.column     = 9'(r_col);
            result.last       = emit_last;
        end
    end

    // --------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= pbu_pkg::RST_IMAGE_WIDTH;
            r_image_height <= pbu_pkg::RST_IMAGE_HEIGHT;
            r_plane_count  <= pbu_pkg::RST_PLANE_COUNT;
            r_has_mask     <= pbu_pkg::RST_HAS_MASK;
            r_compressed   <= pbu_pkg::RST_COMPRESSED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pbu_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                pbu_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                pbu_pkg::CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[4:0];
                pbu_pkg::CFG_HAS_MASK:     r_has_mask     <= i_cfg_data[0];
                pbu_pkg::CFG_COMPRESSED:   r_compressed   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_body_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_phase   <= pbu_pkg::PH_HEADER;
            r_pending <= '0;
            r_col     <= '0;
            r_plane   <= '0;
            r_row     <= '0;
            r_error   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_col     <= n_col;
            r_plane   <= n_plane;
            r_row     <= n_row;
            r_error   <= n_error;
            r_done    <= n_done;
        end
    end

    // ------------------------------------------------------------ output queue
    pbu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit || emit_err),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_value      = out_data.value;
    assign o_run_length = out_data.run_length;
    assign o_plane      = out_data.plane;
    assign o_is_mask    = out_data.is_mask;
    assign o_row        = out_data.row;
    assign o_column     = out_data.column;
    assign o_last       = out_data.last;
    assign o_error      = out_data.error;

endmodule

// File: hdl/pbu_checker.sv
// ----------------------------------------------------------------------------
// pbu_checker
// Port-level checks of the planar bitmap body unpacker, bound to the top.
// ----------------------------------------------------------------------------
module pbu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_value,
    input logic [7:0]  o_run_length,
    input logic [4:0]  o_plane,
    input logic        o_is_mask,
    input logic [11:0] o_row,
    input logic [8:0]  o_column,
    input logic        o_last,
    input logic        o_error
);

    // an error run carries nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_value == 8'd0 && o_run_length == 8'd0 &&
                                  o_plane == 5'd0 && !o_is_mask && o_row == 12'd0 &&
                                  o_column == 9'd0 && !o_last))
        else $error("error run with nonzero fields");

    // a decoded run covers one to 128 bytes
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error) |-> (o_run_length != 8'd0 && o_run_length <= 8'd128))
        else $error("run length out of range");

    // the mask plane follows at least one bit plane
    a_mask_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_mask) |-> (o_plane != 5'd0 && !o_error))
        else $error("mask run on plane zero");

    // a stalled run holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value) &&
                                   $stable(o_run_length) && $stable(o_column) &&
                                   $stable(o_row) && $stable(o_last)))
        else $error("stalled run changed");

endmodule

bind planar_bitmap_body_unpacker_top pbu_checker u_pbu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_value      (o_value),
    .o_run_length (o_run_length),
    .o_plane      (o_plane),
    .o_is_mask    (o_is_mask),
    .o_row        (o_row),
    .o_column     (o_column),
    .o_last       (o_last),
    .o_error      (o_error)
);

// File: dv/tb_planar_bitmap_body_unpacker_top.sv
// ----------------------------------------------------------------------------
// tb_planar_bitmap_body_unpacker_top
// Streams planar bitmap body bytes into the unpacker, raw and PackBits, over
// many image geometries. A run tracker decodes every accepted byte itself and
// compares each run request from the block field by field, in order.
// ----------------------------------------------------------------------------
module tb_planar_bitmap_body_unpacker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_PAD   = 6;
    localparam int unsigned PHASE_BYTES = 412;

    typedef logic [7:0] t_body_q[$];

    // Decodes the body the way the block should and holds the runs still owed.
    class run_tracker;
        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic [4:0]  planes_reg;
        logic        mask_reg;
        logic        packed_mode;

        pbu_pkg::t_phase  phase;
        int unsigned      pending;
        int unsigned      col;
        int unsigned      plane_idx;
        int unsigned      row_idx;
        bit               err_seen;
        bit               img_done;

        pbu_pkg::t_result runs_due[$];

        int unsigned n_bytes;
        int unsigned n_ignored;
        int unsigned n_runs;
        int unsigned n_errors;
        int unsigned n_lasts;
        int unsigned n_fail;

        function new();
            width_reg   = pbu_pkg::RST_IMAGE_WIDTH;
            height_reg  = pbu_pkg::RST_IMAGE_HEIGHT;
            planes_reg  = pbu_pkg::RST_PLANE_COUNT;
            mask_reg    = pbu_pkg::RST_HAS_MASK;
            packed_mode = pbu_pkg::RST_COMPRESSED;
            restart();
        endfunction

        function void restart();
            phase     = pbu_pkg::PH_HEADER;
            pending   = 0;
            col       = 0;
            plane_idx = 0;
            row_idx   = 0;
            err_seen  = 0;
            img_done  = 0;
        endfunction

        function void write_reg(logic [pbu_pkg::CFG_IDX_W-1:0] idx,
                                logic [pbu_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                pbu_pkg::CFG_IMAGE_WIDTH:  width_reg   = d;
                pbu_pkg::CFG_IMAGE_HEIGHT: height_reg  = d;
                pbu_pkg::CFG_PLANE_COUNT:  planes_reg  = d[4:0];
                pbu_pkg::CFG_HAS_MASK:     mask_reg    = d[0];
                pbu_pkg::CFG_COMPRESSED:   packed_mode = d[0];
                default: return;
            endcase
            restart();
        endfunction

        function int unsigned plane_row_bytes();
            int unsigned w;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > pbu_pkg::MAX_WIDTH_DEF) w = pbu_pkg::MAX_WIDTH_DEF;
            return ((w + 15) >> 4) << 1;
        endfunction

        function int unsigned image_rows();
            int unsigned h;
            h = height_reg;
            if (h < 1) h = 1;
            if (h > pbu_pkg::MAX_HEIGHT_DEF) h = pbu_pkg::MAX_HEIGHT_DEF;
            return h;
        endfunction

        function int unsigned bit_planes();
            int unsigned p;
            p = planes_reg;
            if (p < 1) p = 1;
            if (p > pbu_pkg::MAX_PLANES_DEF - 1) p = pbu_pkg::MAX_PLANES_DEF - 1;
            return p;
        endfunction

        function int unsigned bytes_left();
            int unsigned rb;
            rb = plane_row_bytes();
            return (col < rb) ? rb - col : 0;
        endfunction

        function bit ignoring();
            return err_seen || img_done;
        endfunction

        // Record the run at the current position, then advance column/plane/row.
        function void push_run(logic [7:0] v, int unsigned len);
            pbu_pkg::t_result r;
            int unsigned      np;
            np           = bit_planes();
            r            = '0;
            r.value      = v;
            r.run_length = 8'(len);
            r.plane      = 5'(plane_idx);
            r.is_mask    = mask_reg && (plane_idx == np);
            r.row        = 12'(row_idx);
            r.column     = 9'(col);
            col += len;
            if (col >= plane_row_bytes()) begin
                col = 0;
                plane_idx++;
                if (plane_idx >= np + mask_reg) begin
                    plane_idx = 0;
                    row_idx++;
                    if (row_idx >= image_rows()) begin
                        row_idx  = 0;
                        img_done = 1;
                        r.last   = 1'b1;
                    end
                end
            end
            runs_due.push_back(r);
        endfunction

        function void decode_byte(logic [7:0] b);
            pbu_pkg::t_result r;
            int unsigned      n;
            n_bytes++;
            if (ignoring()) begin
                n_ignored++;
                return;
            end
            if (!packed_mode) begin
                push_run(b, 1);
                return;
            end
            case (phase)
                pbu_pkg::PH_LITERAL: begin
                    if (pending <= 1) begin
                        pending = 0;
                        phase   = pbu_pkg::PH_HEADER;
                    end else begin
                        pending--;
                    end
                    push_run(b, 1);
                end
                pbu_pkg::PH_REPEAT: begin
                    n       = (pending < 1) ? 1 : pending;
                    pending = 0;
                    phase   = pbu_pkg::PH_HEADER;
                    push_run(b, n);
                end
                default: begin
                    if (b == pbu_pkg::NOOP_HEADER) return;
                    n = (b < pbu_pkg::NOOP_HEADER) ? b + 1 : 257 - b;
                    if (n > bytes_left()) begin
                        // overrun: flag it and drop the rest of the body
                        r        = '0;
                        r.error  = 1'b1;
                        err_seen = 1;
                        runs_due.push_back(r);
                        return;
                    end
                    pending = n;
                    phase   = (b < pbu_pkg::NOOP_HEADER) ? pbu_pkg::PH_LITERAL
                                                         : pbu_pkg::PH_REPEAT;
                end
            endcase
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                n_fail++;
            end
        endfunction

        function void check_run(pbu_pkg::t_result got);
            pbu_pkg::t_result want;
            if (runs_due.size() == 0) begin
                $error("run request with nothing outstanding: value %0d len %0d error %0d",
                       got.value, got.run_length, got.error);
                n_fail++;
                return;
            end
            want = runs_due.pop_front();
            n_runs++;
            if (want.error) n_errors++;
            if (want.last) n_lasts++;
            cmp_field("value", want.value, got.value);
            cmp_field("run_length", want.run_length, got.run_length);
            cmp_field("plane", want.plane, got.plane);
            cmp_field("is_mask", want.is_mask, got.is_mask);
            cmp_field("row", want.row, got.row);
            cmp_field("column", want.column, got.column);
            cmp_field("last", want.last, got.last);
            cmp_field("error", want.error, got.error);
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pbu_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pbu_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [7:0]                     i_body_byte = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [7:0]                     o_value;
    logic [7:0]                     o_run_length;
    logic [4:0]                     o_plane;
    logic                           o_is_mask;
    logic [11:0]                    o_row;
    logic [8:0]                     o_column;
    logic                           o_last;
    logic                           o_error;

    run_tracker  sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned n_cfg_writes = 0;

    planar_bitmap_body_unpacker_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_body_byte  (i_body_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_run_length (o_run_length),
        .o_plane      (o_plane),
        .o_is_mask    (o_is_mask),
        .o_row        (o_row),
        .o_column     (o_column),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                n_cfg_writes++;
            end
            if (i_valid && o_ready) sb.decode_byte(i_body_byte);
            if (o_valid && i_ready) begin
                sb.check_run({o_value, o_run_length, o_plane, o_is_mask,
                              o_row, o_column, o_last, o_error});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_body_byte = b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed run is back, then let the pipe empty.
    task automatic settle();
        i_valid = 1'b0;
        while (sb.runs_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [pbu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbu_pkg::CFG_DATA_W-1:0] d);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_image(input logic [12:0] w, input logic [12:0] h,
                             input logic [4:0] p, input logic m, input logic c);
        write_cfg(pbu_pkg::CFG_IMAGE_WIDTH, w);
        write_cfg(pbu_pkg::CFG_IMAGE_HEIGHT, h);
        write_cfg(pbu_pkg::CFG_PLANE_COUNT, 13'(p));
        write_cfg(pbu_pkg::CFG_HAS_MASK, 13'(m));
        write_cfg(pbu_pkg::CFG_COMPRESSED, 13'(c));
    endtask

    task automatic feed(input t_body_q bq);
        foreach (bq[k]) drive_byte(bq[k]);
    endtask

    // Mostly well-formed headers that fit the row; some no-ops, junk and overruns.
    function automatic logic [7:0] next_body_byte();
        int unsigned left;
        int unsigned top;
        int unsigned n;
        int unsigned r;
        if (!sb.packed_mode || sb.phase != pbu_pkg::PH_HEADER) begin
            return 8'($urandom_range(255));
        end
        left = sb.bytes_left();
        top  = (left < 128) ? left : 128;
        r    = $urandom_range(99);
        if (r < 3) return pbu_pkg::NOOP_HEADER;
        if (r < 6) return 8'($urandom_range(255));
        if (r < 8 && left < 128) begin
            n = $urandom_range(128, left + 1);
        end else if ($urandom_range(1)) begin
            n = $urandom_range(top, 1);
        end else begin
            n = $urandom_range((top < 4) ? top : 4, 1);
        end
        if (n == 1 || $urandom_range(1)) return 8'(n - 1);
        return 8'(257 - n);
    endfunction

    task automatic run_segment(input int unsigned cap, inout int unsigned live);
        int unsigned sent;
        sent = 0;
        while (!sb.ignoring() && sent < cap) begin
            if ($urandom_range(199) == 0) begin
                // pause mid-image; an out-of-list index must not restart it
                settle();
                if ($urandom_range(1)) begin
                    write_cfg(pbu_pkg::CFG_COMPRESSED + 3'($urandom_range(3, 1)),
                              13'($urandom_range(8191)));
                end
            end
            drive_byte(next_body_byte());
            sent++;
        end
        if (sb.ignoring()) begin
            repeat ($urandom_range(2)) drive_byte(8'($urandom_range(255)));
        end
        live += sent;
        settle();
    endtask

    task automatic run_phase(input int unsigned target);
        int unsigned   live;
        logic [12:0]   vals[5];
        int unsigned   pick;
        int unsigned   seg;
        live = 0;
        while (live < target) begin
            case ($urandom_range(9))
                0: vals[0] = 13'd0;
                1: vals[0] = 13'd1;
                2: vals[0] = 13'd4096;
                3: vals[0] = 13'($urandom_range(8191));
                4: vals[0] = 13'($urandom_range(1000, 65));
                default: vals[0] = 13'($urandom_range(64, 1));
            endcase
            case ($urandom_range(9))
                0: vals[1] = 13'd0;
                1: vals[1] = 13'd4096;
                2: vals[1] = 13'($urandom_range(8191));
                3, 4: vals[1] = 13'($urandom_range(40, 5));
                default: vals[1] = 13'($urandom_range(4, 1));
            endcase
            case ($urandom_range(9))
                0: vals[2] = 13'd0;
                1: vals[2] = 13'd24;
                2: vals[2] = 13'($urandom_range(31));
                default: vals[2] = 13'($urandom_range(6, 1));
            endcase
            vals[3] = 13'($urandom_range(1));
            vals[4] = 13'($urandom_range(3) != 0);
            if ($urandom_range(4) == 0) begin
                pick = $urandom_range(4);
                write_cfg(pbu_pkg::CFG_IMAGE_WIDTH + 3'(pick), vals[pick]);
            end else begin
                set_image(vals[0], vals[1], vals[2][4:0], vals[3][0], vals[4][0]);
            end
            // keep the phase close to its byte budget
            seg = $urandom_range(250, 30);
            if (seg > target - live) seg = target - live;
            run_segment(seg, live);
        end
    endtask

    initial begin
        t_body_q bq;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry: 40-byte rows, packed. Literal, repeat, no-op, data
        // bytes 128 and 127, then a 128-literal header that overruns the row.
        bq = '{8'h00, 8'h00, 8'hFF, 8'hFF, pbu_pkg::NOOP_HEADER, 8'h01, 8'h80, 8'h7F,
               8'h7F, 8'h33};
        feed(bq);
        settle();

        // 2-byte rows, one plane plus mask, single row: ends the image.
        set_image(13'd16, 13'd1, 5'd1, 1'b1, 1'b1);
        bq = '{8'hFF, 8'hAA};
        feed(bq);
        settle();
        write_cfg(pbu_pkg::CFG_COMPRESSED + 3'd1, 13'h1FFF);
        bq = '{8'h01, 8'h00, 8'hFF, 8'h81};
        feed(bq);
        settle();

        // Raw body, width and plane count below range, two rows.
        set_image(13'd0, 13'd2, 5'd0, 1'b0, 1'b0);
        bq = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        feed(bq);
        settle();

        // Widest row with a 128-copy repeat.
        set_image(13'd4096, 13'd1, 5'd1, 1'b0, 1'b1);
        bq = '{8'h81, 8'h5A};
        feed(bq);
        settle();

        run_phase(PHASE_BYTES);
        send_idle_pct = 77;
        run_phase(PHASE_BYTES);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        run_phase(PHASE_BYTES);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        run_phase(PHASE_BYTES);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        repeat (20) @(negedge i_clk);

        $display("Run: %0d body bytes (%0d dropped after end or overrun), %0d register writes",
                 sb.n_bytes, sb.n_ignored, n_cfg_writes);
        $display("Run: %0d runs checked, %0d overrun flags, %0d image ends, %0d mismatches",
                 sb.n_runs, sb.n_errors, sb.n_lasts, sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
